[design/pip_pkg.sv]
// Shared types for the point-in-polygon tester.
// Holds the input mode codes, controller states and the control/status words
// between controller and datapath. No dependencies.
package pip_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_TEST   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;       // empty the vertex store, drop the overflow flag
        logic append;      // store the input word as a vertex
        logic start;       // latch the test point, zero the crossing parity
        logic rd_en;       // read one vertex from the store
        logic rd_first;    // this read only primes the previous-vertex register
        logic res_ld;      // load the result register
        logic res_parity;  // result takes the crossing parity, else zero
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic few;         // fewer than three vertices stored
        logic pipe_empty;  // no edge in flight
    } t_sts;

    localparam int MIN_VERTICES = 3;
    localparam int COUNT_OUT_W  = 7;

endpackage

[design/pip_ctrl.sv]
// Controller for the point-in-polygon tester: handshakes and edge sequencing.
// Depends on pip_pkg; drives pip_dp through t_cmd and reads back t_sts.
module pip_ctrl #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_mode,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  pip_pkg::t_sts                     i_sts,
    input  logic [$clog2(MAX_VERTICES)-1:0]   i_last_addr,
    output pip_pkg::t_cmd                     o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_rd_addr
);
    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_first, n_first;
    logic            r_out_vld, n_out_vld;
    logic            out_free;
    logic            in_acc;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_rd_addr   = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_first   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_first   <= n_first;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_first   = r_first;
        n_out_vld = r_out_vld;
        o_cmd     = '0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_mode)
                        MODE_CLEAR:  o_cmd.clear  = 1'b1;
                        MODE_APPEND: o_cmd.append = 1'b1;
                        default:     ;
                    endcase
                    if (i_mode == MODE_TEST && !i_sts.few) begin
                        // walk from the closing vertex round to the last one
                        o_cmd.start = 1'b1;
                        n_idx       = i_last_addr;
                        n_first     = 1'b1;
                        n_state     = S_SCAN;
                    end else begin
                        o_cmd.res_ld = 1'b1;
                        n_out_vld    = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = r_first;
                n_first        = 1'b0;
                if (r_first) begin
                    n_idx = '0;
                end else if (r_idx == i_last_addr) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_parity = 1'b1;
                    n_out_vld        = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[design/pip_dp.sv]
// Datapath for the point-in-polygon tester: vertex store, count, overflow flag,
// edge pipeline (span check, two products, compare) and crossing parity.
// Depends on pip_pkg; commanded by pip_ctrl.
module pip_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pip_pkg::t_cmd                     i_cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]   i_rd_addr,
    input  logic [15:0]                       i_x,
    input  logic [15:0]                       i_y,
    output pip_pkg::t_sts                     o_sts,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_last_addr,
    output logic                              o_inside,
    output logic [pip_pkg::COUNT_OUT_W-1:0]   o_count,
    output logic                              o_overflow
);
    import pip_pkg::*;

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;

    logic signed [CW-1:0] mem_x [MAX_VERTICES];
    logic signed [CW-1:0] mem_y [MAX_VERTICES];

    logic [CNT_W-1:0]     r_count;
    logic                 r_ovf;
    logic                 r_inside;
    logic                 r_parity;
    logic signed [CW-1:0] r_px, r_py;

    logic                 r_rd_vld, r_rd_first;
    logic signed [CW-1:0] r_rd_x, r_rd_y;
    logic signed [CW-1:0] r_prev_x, r_prev_y;

    logic                 r_e_vld, r_e_ok;
    logic signed [DW-1:0] r_da, r_db, r_dc, r_dd;

    logic                 r_p_vld, r_p_ok;
    logic signed [PW-1:0] r_p1, r_p2;

    logic [31:0]          x_wide, y_wide;
    logic signed [CW-1:0] x_c, y_c;
    logic                 full;
    logic [CNT_W-1:0]     cnt_m1;
    logic [31:0]          cnt_wide;

    // take the low COORD_BITS of each field as two's complement
    assign x_wide = {16'd0, i_x};
    assign y_wide = {16'd0, i_y};
    assign x_c    = x_wide[CW-1:0];
    assign y_c    = y_wide[CW-1:0];

    assign full        = (r_count == CNT_W'(MAX_VERTICES));
    assign cnt_m1      = r_count - CNT_W'(1);
    assign o_last_addr = cnt_m1[AW-1:0];
    assign cnt_wide    = 32'(r_count);
    assign o_count     = cnt_wide[COUNT_OUT_W-1:0];
    assign o_overflow  = r_ovf;
    assign o_inside    = r_inside;

    assign o_sts.few        = (r_count < CNT_W'(MIN_VERTICES));
    assign o_sts.pipe_empty = !r_rd_vld && !r_e_vld && !r_p_vld;

    // vertex store
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            mem_x[r_count[AW-1:0]] <= x_c;
            mem_y[r_count[AW-1:0]] <= y_c;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= mem_x[i_rd_addr];
            r_rd_y <= mem_y[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.append) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // edge stage: orient the edge, check the span, form the differences
    logic                 e_ok;
    logic signed [CW-1:0] xl, yl, xu, yu;
    always_comb begin
        if (r_prev_y < r_rd_y) begin
            xl = r_prev_x; yl = r_prev_y; xu = r_rd_x; yu = r_rd_y;
        end else begin
            xl = r_rd_x; yl = r_rd_y; xu = r_prev_x; yu = r_prev_y;
        end
        e_ok = (r_prev_y != r_rd_y) && (r_py > yl) && (r_py <= yu);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_e_vld  <= 1'b0;
            r_p_vld  <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            r_e_vld  <= r_rd_vld && !r_rd_first;
            r_p_vld  <= r_e_vld;
            if (i_cmd.start) begin
                r_parity <= 1'b0;
            end else if (r_p_vld && r_p_ok && (r_p1 < r_p2)) begin
                r_parity <= !r_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= i_cmd.rd_first;
        if (i_cmd.start) begin
            r_px <= x_c;
            r_py <= y_c;
        end
        if (r_rd_vld) begin
            r_prev_x <= r_rd_x;
            r_prev_y <= r_rd_y;
        end
        r_e_ok <= e_ok;
        r_da   <= {r_px[CW-1], r_px} - {xl[CW-1], xl};
        r_db   <= {yu[CW-1], yu} - {yl[CW-1], yl};
        r_dc   <= {r_py[CW-1], r_py} - {yl[CW-1], yl};
        r_dd   <= {xu[CW-1], xu} - {xl[CW-1], xl};
        // crossing when (px-xl)*(yu-yl) < (py-yl)*(xu-xl)
        r_p_ok <= r_e_ok;
        r_p1   <= r_da * r_db;
        r_p2   <= r_dc * r_dd;
        if (i_cmd.res_ld) begin
            r_inside <= i_cmd.res_parity && r_parity;
        end
    end

endmodule

[design/point_in_polygon_test_top.sv]
// Top level of the point-in-polygon tester.
// Depends on pip_pkg, pip_ctrl and pip_dp.
//
// Input stream (s_axis): one word per command. tuser carries the mode (clear,
// append vertex, test point); tdata carries x and y as 16-bit two's complement.
// Output stream (m_axis): exactly one word per input word, in order, carrying
// the inside flag, the stored vertex count and the sticky overflow flag.
//
// Clear and append finish in the cycle they are taken; their result is valid on
// the next cycle. A test with n stored vertices reads the store once per cycle,
// n + 1 reads, then drains a four-stage edge pipeline (store read, span check,
// multiply, compare) before its result appears. A test on fewer than three
// vertices answers at once. One word is worked on at a time.
//
// Reset (synchronous, active low) empties the store and clears the overflow
// flag and the output valid flag. When the receiver stalls, the result holds in
// the output register; a new word is still taken if that register is being
// emptied in the same cycle, otherwise s_axis_tready stays low.
module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] point_x, [31:16] point_y
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] inside_res, [7:1] vertex_count,
                                        // [8] overflow, [15:9] zero
);
    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    t_cmd                    cmd;
    t_sts                    sts;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           last_addr;
    logic                    pt_in;
    logic [COUNT_OUT_W-1:0]  count;
    logic                    overflow;

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .i_last_addr (last_addr),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr)
    );

    pip_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_x         (s_axis_tdata[15:0]),
        .i_y         (s_axis_tdata[31:16]),
        .o_sts       (sts),
        .o_last_addr (last_addr),
        .o_inside    (pt_in),
        .o_count     (count),
        .o_overflow  (overflow)
    );

    assign m_axis_tdata = {7'd0, overflow, count, pt_in};

endmodule
